>>> rtl/deq_pkg.sv
// Types and constants shared by the double-ended queue block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int WORD_W = 32;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

  typedef enum logic [2:0] {
    FUNC_NONE       = 3'd0,
    FUNC_PUSH_FRONT = 3'd1,
    FUNC_PUSH_BACK  = 3'd2,
    FUNC_POP_FRONT  = 3'd3,
    FUNC_POP_BACK   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_UNDER = 2'd1,
    STATUS_OVER  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_HOLD       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e                  cmd;
    logic signed [WORD_W-1:0]   value;
  } cell_ctrl_t;

endpackage

>>> rtl/deq_cell.sv
// One storage cell of the deque chain: a word and its occupied flag.
// Depends on deq_pkg for the cell command struct.
`timescale 1ns / 1ps

module deq_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  deq_pkg::cell_ctrl_t               ctrl_i,
  input  logic                              left_valid_i,
  input  logic signed [deq_pkg::WORD_W-1:0] left_data_i,
  input  logic                              right_valid_i,
  input  logic signed [deq_pkg::WORD_W-1:0] right_data_i,
  output logic                              valid_o,
  output logic signed [deq_pkg::WORD_W-1:0] data_o
);
  import deq_pkg::*;

  logic                     valid_d, valid_q;
  logic signed [WORD_W-1:0] data_d, data_q;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    unique case (ctrl_i.cmd)
      CMD_PUSH_FRONT: begin
        valid_d = left_valid_i;
        data_d  = left_data_i;
      end
      CMD_POP_FRONT: begin
        valid_d = right_valid_i;
        data_d  = right_data_i;
      end
      CMD_PUSH_BACK: begin
        if (left_valid_i && !valid_q) begin
          valid_d = 1'b1;
          data_d  = ctrl_i.value;
        end
      end
      CMD_POP_BACK: begin
        if (valid_q && !right_valid_i) begin
          valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/double_ended_queue_top.sv
// Top level of the double-ended queue: command decode, element count,
// result register and the chain of deq_cell instances. Depends on deq_pkg.
//
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------------
//   input   | in_valid_i / in_stall_o   | func_i, value_i
//   output  | out_valid_o / out_stall_i | front_value_o, back_value_o,
//           |                           | element_count_o, is_empty_o, status_o
//
// One transaction per cycle sustained while the output is not stalled; the cell
// chain and the pending status update at the accepting edge, and the result
// register loads from the chain once the pending result can move into it.
// Reset clears all occupied flags, the count and both handshake stages.
// An output stall holds the result register; the input stalls only while a
// pending result cannot move into it.
`timescale 1ns / 1ps

module double_ended_queue_top #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int CntW  = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        func_i,
  input  logic signed [deq_pkg::WORD_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [deq_pkg::WORD_W-1:0] front_value_o,
  output logic signed [deq_pkg::WORD_W-1:0] back_value_o,
  output logic [CntW-1:0]                   element_count_o,
  output logic                              is_empty_o,
  output logic [1:0]                        status_o
);
  import deq_pkg::*;

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                     in_accept, out_load, full, empty;
  cell_ctrl_t               ctrl;
  status_e                  status_d, pend_status_q;
  logic [CntW-1:0]          count_d, count_q, count_m1;
  logic [IdxW-1:0]          back_idx;
  logic                     pend_q, out_valid_q;
  logic signed [WORD_W-1:0] front_q, back_q;
  logic [CntW-1:0]          out_count_q;
  logic                     out_empty_q;
  status_e                  out_status_q;

  logic [DEPTH-1:0]         cell_valid;
  logic signed [WORD_W-1:0] cell_data [DEPTH];

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_load  = pend_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = pend_q && !out_load;

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    ctrl.cmd   = CMD_HOLD;
    ctrl.value = value_i;
    status_d   = STATUS_OK;
    count_d    = count_q;
    if (in_accept) begin
      unique case (func_i) inside
        FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
          if (full) begin
            status_d = STATUS_OVER;
          end else begin
            ctrl.cmd = (func_i == FUNC_PUSH_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            count_d  = count_q + CntW'(1);
          end
        end
        FUNC_POP_FRONT, FUNC_POP_BACK: begin
          if (empty) begin
            status_d = STATUS_UNDER;
          end else begin
            ctrl.cmd = (func_i == FUNC_POP_FRONT) ? CMD_POP_FRONT : CMD_POP_BACK;
            count_d  = count_q - CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     lv, rv;
    logic signed [WORD_W-1:0] ld, rd;
    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = value_i;
    end else begin : g_mid_l
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_r
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end
    deq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_valid_i  (lv),
      .left_data_i   (ld),
      .right_valid_i (rv),
      .right_data_i  (rd),
      .valid_o       (cell_valid[i]),
      .data_o        (cell_data[i])
    );
  end

  assign count_m1 = count_q - CntW'(1);
  assign back_idx = count_m1[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_accept) begin
        pend_q <= 1'b1;
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_status_q <= status_d;
    end
    if (out_load) begin
      front_q      <= empty ? EMPTY_WORD : cell_data[0];
      back_q       <= empty ? EMPTY_WORD : cell_data[back_idx];
      out_count_q  <= count_q;
      out_empty_q  <= empty;
      out_status_q <= pend_status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign front_value_o   = front_q;
  assign back_value_o    = back_q;
  assign element_count_o = out_count_q;
  assign is_empty_o      = out_empty_q;
  assign status_o        = out_status_q;

endmodule

>>> rtl/deq_checker.sv
// Port-level checks for double_ended_queue_top, attached by bind.
// Depends on deq_pkg for the word width and the empty marker.
`timescale 1ns / 1ps

module deq_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
  parameter int CntW  = $clog2(DEPTH + 1)
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [deq_pkg::WORD_W-1:0] front_value_o,
  input logic signed [deq_pkg::WORD_W-1:0] back_value_o,
  input logic [CntW-1:0]                   element_count_o,
  input logic                              is_empty_o,
  input logic [1:0]                        status_o
);
  import deq_pkg::*;

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(front_value_o)
      && $stable(back_value_o) && $stable(element_count_o) && $stable(status_o))
    else $error("result changed under stall");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (element_count_o == '0)))
    else $error("empty flag disagrees with count");

  a_empty_words : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> front_value_o == EMPTY_WORD
      && back_value_o == EMPTY_WORD)
    else $error("empty deque reports a stored word");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> element_count_o <= CntW'(DEPTH))
    else $error("count beyond depth");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_OK || status_o == STATUS_UNDER
      || status_o == STATUS_OVER))
    else $error("undefined status code");

endmodule

bind double_ended_queue_top deq_checker #(
  .DEPTH (DEPTH),
  .CntW  (CntW)
) u_deq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .front_value_o   (front_value_o),
  .back_value_o    (back_value_o),
  .element_count_o (element_count_o),
  .is_empty_o      (is_empty_o),
  .status_o        (status_o)
);
